[design/hard_sphere_overlap_insert_defines.svh]
// Assertion macros for the checker file.
`ifndef HARD_SPHERE_OVERLAP_INSERT_DEFINES_SVH
`define HARD_SPHERE_OVERLAP_INSERT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define HSOI_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define HSOI_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/hsoi_pkg.sv]
package hsoi_pkg;

	localparam int MAX_SPHERES = 1024;
	localparam int COORD_BITS  = 24;

	localparam int ADDR_W   = $clog2(MAX_SPHERES);
	localparam int CNT_W    = 11;
	localparam int REJ_W    = 16;
	localparam int HB_W     = 22;
	localparam int CUT_W    = 48;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 48;
	localparam int ENTRY_W  = 3 * COORD_BITS;
	localparam int DIFF_W   = COORD_BITS + 2;
	localparam int MAG_W    = 24;
	localparam int SQ_W     = 2 * MAG_W;
	localparam int SUM_W    = SQ_W + 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_HALF_BOX     = 2'd0,
		CFG_CUTOFF_SQ    = 2'd1,
		CFG_TARGET_COUNT = 2'd2
	} hsoi_cfg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} hsoi_state_t;

	typedef struct packed {
		logic load;
		logic rd_en;
		logic finish;
	} hsoi_cmd_t;

	typedef struct packed {
		logic scan_needed;
		logic last_addr;
		logic pipe_empty;
	} hsoi_sts_t;

endpackage

[design/hsoi_ctrl.sv]
module hsoi_ctrl
	import hsoi_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  hsoi_sts_t sts,
	output hsoi_cmd_t cmd
);

	hsoi_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		busy       = 1'b1;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					state_d  = sts.scan_needed ? ST_SCAN : ST_FINISH;
				end
			end
			ST_SCAN: begin
				cmd.rd_en = 1'b1;
				if (sts.last_addr) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				// wait for the last compare to land in the hit flag
				if (sts.pipe_empty) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				cmd.finish = 1'b1;
				state_d    = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

[design/hsoi_datapath.sv]
module hsoi_datapath
	import hsoi_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  hsoi_cmd_t              cmd,
	output hsoi_sts_t              sts,
	input  logic                   cfg_valid,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DAT_W-1:0]   cfg_data,
	input  logic                   func,
	input  logic [COORD_BITS-1:0]  cand_x,
	input  logic [COORD_BITS-1:0]  cand_y,
	input  logic [COORD_BITS-1:0]  cand_z,
	output logic                   res_strobe,
	output logic                   accepted,
	output logic [CNT_W-1:0]       placed_count,
	output logic [REJ_W-1:0]       rejections,
	output logic                   done_res
);

	// configuration
	logic [HB_W-1:0]  half_box_q;
	logic [CUT_W-1:0] cutoff_sq_q;
	logic [CNT_W-1:0] target_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_box_q  <= HB_W'(65536);
			cutoff_sq_q <= CUT_W'(64'd4294967296);
			target_q    <= CNT_W'(1024);
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_HALF_BOX:     half_box_q  <= cfg_data[HB_W-1:0];
				CFG_CUTOFF_SQ:    cutoff_sq_q <= cfg_data[CUT_W-1:0];
				CFG_TARGET_COUNT: target_q    <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// placement state and request latch
	logic [CNT_W-1:0]   placed_q;
	logic [REJ_W-1:0]   rej_q;
	logic [ADDR_W-1:0]  addr_q;
	logic               func_q;
	logic               elig_q;
	logic               hit_q;
	logic [ENTRY_W-1:0] cand_q;
	logic               can_place;

	assign can_place = (placed_q < target_q) && (placed_q < CNT_W'(MAX_SPHERES));

	// centre store: one write port, one registered read port
	logic [ENTRY_W-1:0] store_mem [MAX_SPHERES];
	logic [ENTRY_W-1:0] rd_data_s1;
	logic               v_s1;

	always_ff @(posedge clk) begin
		if (cmd.finish && !func_q && elig_q && !hit_q) begin
			store_mem[placed_q[ADDR_W-1:0]] <= cand_q;
		end
		if (cmd.rd_en) begin
			rd_data_s1 <= store_mem[addr_q];
		end
	end

	// fold one axis to its minimum image and take the magnitude
	function automatic logic [MAG_W:0] fold_mag(input logic [COORD_BITS-1:0] a,
			input logic [COORD_BITS-1:0] b, input logic [HB_W-1:0] hb);
		logic signed [DIFF_W-1:0] d;
		logic signed [DIFF_W-1:0] hbe;
		logic [DIFF_W-1:0]        m;
		d   = $signed({{2{a[COORD_BITS-1]}}, a}) - $signed({{2{b[COORD_BITS-1]}}, b});
		hbe = $signed({{(DIFF_W-HB_W){1'b0}}, hb});
		if (d > hbe) begin
			d = d - (hbe <<< 1);
		end else if (d < -hbe) begin
			d = d + (hbe <<< 1);
		end
		m = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
		// top bit flags a component too far to overlap
		fold_mag = {(m[DIFF_W-1:MAG_W] != '0), m[MAG_W-1:0]};
	endfunction

	logic [MAG_W-1:0] mag_s2 [3];
	logic             far_s2;
	logic             v_s2;
	logic [SQ_W-1:0]  sq_s3 [3];
	logic             far_s3;
	logic             v_s3;
	logic [MAG_W:0]   fm [3];
	logic [SUM_W-1:0] dist_sq;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			fm[k] = fold_mag(cand_q[k*COORD_BITS +: COORD_BITS],
				rd_data_s1[k*COORD_BITS +: COORD_BITS], half_box_q);
		end
		dist_sq = SUM_W'(sq_s3[0]) + SUM_W'(sq_s3[1]) + SUM_W'(sq_s3[2]);
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			mag_s2[k] <= fm[k][MAG_W-1:0];
			sq_s3[k]  <= SQ_W'(mag_s2[k]) * SQ_W'(mag_s2[k]);
		end
		far_s2 <= fm[0][MAG_W] | fm[1][MAG_W] | fm[2][MAG_W];
		far_s3 <= far_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= cmd.rd_en;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// next counters at the end of a request
	logic [CNT_W-1:0] placed_d;
	logic [REJ_W-1:0] rej_d;
	logic             acc_d;

	always_comb begin
		placed_d = placed_q;
		rej_d    = rej_q;
		acc_d    = 1'b0;
		if (func_q) begin
			placed_d = '0;
			rej_d    = '0;
		end else if (elig_q) begin
			if (hit_q) begin
				if (rej_q != '1) begin
					rej_d = rej_q + REJ_W'(1);
				end
			end else begin
				placed_d = placed_q + CNT_W'(1);
				rej_d    = '0;
				acc_d    = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			placed_q   <= '0;
			rej_q      <= '0;
			addr_q     <= '0;
			func_q     <= 1'b0;
			elig_q     <= 1'b0;
			hit_q      <= 1'b0;
			res_strobe <= 1'b0;
		end else begin
			res_strobe <= cmd.finish;
			if (cmd.load) begin
				func_q <= func;
				elig_q <= can_place;
				addr_q <= '0;
				hit_q  <= 1'b0;
			end else begin
				if (cmd.rd_en) begin
					addr_q <= addr_q + ADDR_W'(1);
				end
				if (v_s3 && !far_s3 && (dist_sq < SUM_W'(cutoff_sq_q))) begin
					hit_q <= 1'b1;
				end
			end
			if (cmd.finish) begin
				placed_q <= placed_d;
				rej_q    <= rej_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cand_q <= {cand_z, cand_y, cand_x};
		end
		if (cmd.finish) begin
			accepted     <= acc_d;
			placed_count <= placed_d;
			rejections   <= rej_d;
			done_res     <= (placed_d >= target_q);
		end
	end

	assign sts.scan_needed = !func && can_place && (placed_q != '0);
	assign sts.last_addr   = ({1'b0, addr_q} == (placed_q - CNT_W'(1)));
	assign sts.pipe_empty  = !(v_s1 || v_s2 || v_s3);

endmodule

[design/hard_sphere_overlap_insert.sv]
// Hard-sphere placement in a cubic periodic box. A request is taken when start is high and
// busy is low; func selects a candidate proposal or a restart. Every proposal is checked
// against each stored centre through the single read port of the centre store, one centre
// per cycle; a restart, a proposal into an empty store, and a proposal after the target is
// met skip this scan and go straight to the result.
// Each result is shown for exactly one cycle with res_strobe high and must be captured
// then: it cannot be held back. busy is low during the result cycle, so the next request
// may be issued alongside it. Configuration writes are taken at any time (cfg_ready is
// always high) but are meant for idle periods only.
module hard_sphere_overlap_insert
	import hsoi_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic                  func,
	input  logic [COORD_BITS-1:0] cand_x,
	input  logic [COORD_BITS-1:0] cand_y,
	input  logic [COORD_BITS-1:0] cand_z,
	output logic                  res_strobe,
	output logic                  accepted,
	output logic [CNT_W-1:0]      placed_count,
	output logic [REJ_W-1:0]      rejections,
	output logic                  done_res,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DAT_W-1:0]  cfg_data
);

	hsoi_cmd_t cmd;
	hsoi_sts_t sts;

	assign cfg_ready = 1'b1;

	hsoi_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.cmd    (cmd)
	);

	hsoi_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.cfg_valid    (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.func         (func),
		.cand_x       (cand_x),
		.cand_y       (cand_y),
		.cand_z       (cand_z),
		.res_strobe   (res_strobe),
		.accepted     (accepted),
		.placed_count (placed_count),
		.rejections   (rejections),
		.done_res     (done_res)
	);

endmodule

[design/hsoi_checker.sv]
`include "hard_sphere_overlap_insert_defines.svh"

module hsoi_checker
	import hsoi_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  start,
	input logic                  busy,
	input logic                  res_strobe,
	input logic                  accepted,
	input logic [CNT_W-1:0]      placed_count,
	input logic [REJ_W-1:0]      rejections
);

	// a taken request keeps the block busy on the following cycle
	`HSOI_ASSERT_NXT(a_take_busy, start && !busy, busy, "busy not raised after request")

	// results are single-cycle pulses, one request apart
	`HSOI_ASSERT_NXT(a_strobe_pulse, res_strobe, !res_strobe, "result strobe longer than one cycle")

	// a result is only issued once the block has gone idle
	`HSOI_ASSERT_IMP(a_strobe_idle, res_strobe, !busy, "result strobe while busy")

	// an accepted candidate clears the rejection run and counts at least one sphere
	`HSOI_ASSERT_IMP(a_acc_counts, res_strobe && accepted,
		(rejections == '0) && (placed_count != '0), "accepted result with bad counters")

endmodule

bind hard_sphere_overlap_insert hsoi_checker u_hsoi_checker (.*);
